/* design/mcoc_pkg.sv */
// Shared types, constants and saturating arithmetic for the matrix chain cost block.
`timescale 1ns / 1ps
`default_nettype none

package mcoc_pkg;

  localparam int DIM_IN_W = 12;
  localparam int COST_W   = 48;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [DIM_IN_W-1:0] dimension;
    logic                last;
  } request_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflow;
  } result_t;

  typedef struct packed {
    logic valid;
    logic head;
    logic first;
    logic last;
  } step_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/mcoc_unit.sv */
// Dimension store, cost table and the shared multiply, add and minimum pipeline.
`timescale 1ns / 1ps
`default_nettype none

module mcoc_unit import mcoc_pkg::*; #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 12
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    wr_en,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]       wr_addr,
  input  wire logic [DIM_BITS-1:0]                     wr_data,
  input  wire step_t                                   step,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] i,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] j,
  input  wire logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] k,
  output logic                                         pipe_busy,
  output logic [COST_W-1:0]                            cost
);

  localparam int IW  = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int DW  = $clog2(MAX_MATRICES + 1);
  localparam int MW  = 2 * DIM_BITS;
  localparam int PW  = 3 * DIM_BITS;
  localparam int CAW = 2 * IW;

  logic [DIM_BITS-1:0] dim_mem [0:MAX_MATRICES];
  logic [COST_W-1:0]   cost_mem [0:(2**CAW)-1];

  logic [DW-1:0]       addr_a;
  logic [DW-1:0]       addr_b;
  logic [IW-1:0]       kp1;
  logic [DIM_BITS-1:0] da;
  logic [DIM_BITS-1:0] db;
  logic [COST_W-1:0]   cl;
  logic [COST_W-1:0]   cr;

  logic                v1, v2, v3, v4;
  logic                h1;
  logic                f1, f2, f3, f4;
  logic                l1, l2, l3, l4;
  logic [CAW-1:0]      a1, a2, a3, a4;
  logic [DIM_BITS-1:0] di_hold;
  logic [DIM_BITS-1:0] dj2;
  logic [MW-1:0]       m2;
  logic [COST_W-1:0]   sum2, sum3;
  logic [PW-1:0]       p3;
  logic [COST_W-1:0]   c4;
  logic [COST_W-1:0]   best;
  logic [COST_W-1:0]   best_next;
  logic [COST_W-1:0]   left;
  logic [COST_W-1:0]   right;

  assign kp1    = k + 1'b1;
  assign addr_a = step.head ? DW'(i) : DW'(kp1);
  assign addr_b = DW'(j) + 1'b1;
  assign left   = f1 ? '0 : cl;
  assign right  = l1 ? '0 : cr;

  always_comb begin
    if (f4 || (c4 < best)) begin
      best_next = c4;
    end else begin
      best_next = best;
    end
  end

  assign pipe_busy = v1 | v2 | v3 | v4;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dim_mem[wr_addr] <= wr_data;
    end
    da <= dim_mem[addr_a];
    db <= dim_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (v4 && l4) begin
      cost_mem[a4] <= best_next;
    end
    cl <= cost_mem[{i, k}];
    cr <= cost_mem[{kp1, j}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= step.valid;
      v2 <= v1 && !h1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    h1 <= step.head;
    f1 <= step.first;
    l1 <= step.last;
    a1 <= {i, j};
    if (v1 && h1) begin
      di_hold <= da;
    end
    f2   <= f1;
    l2   <= l1;
    a2   <= a1;
    m2   <= MW'(di_hold) * MW'(da);
    sum2 <= sat_add(left, right);
    dj2  <= db;
    f3   <= f2;
    l3   <= l2;
    a3   <= a2;
    p3   <= PW'(m2) * PW'(dj2);
    sum3 <= sum2;
    f4   <= f3;
    l4   <= l3;
    a4   <= a3;
    c4   <= sat_add(sum3, COST_W'(p3));
    if (v4) begin
      best <= best_next;
      if (l4) begin
        cost <= best_next;
      end
    end
  end

  a_head_feeds_first: assert property (@(posedge clk) disable iff (rst)
    (v1 && f1 && !h1) |-> $past(step.valid && step.head, 2))
    else $error("first split step without a preceding interval head");

endmodule

`default_nettype wire

/* design/mcoc_seq.sv */
// Sequencer that walks chain length, interval and split point for the cost pipeline.
`timescale 1ns / 1ps
`default_nettype none

module mcoc_seq import mcoc_pkg::*; #(
  parameter int MAX_MATRICES = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    go,
  input  wire logic [$clog2(MAX_MATRICES+1)-1:0]       nmat,
  input  wire logic                                    pipe_busy,
  output step_t                                        step,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] i,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] j,
  output logic [((MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1)-1:0] k,
  output logic                                         done
);

  localparam int IW = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int LW = $clog2(MAX_MATRICES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_ISSUE,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t        state;
  logic [LW-1:0] len;
  logic [LW-1:0] n;
  logic          k_last;
  logic          j_end;

  assign k_last = ((k + 1'b1) == j);
  assign j_end  = ((LW'(j) + 1'b1) == n);

  always_comb begin
    step.valid = (state == S_HEAD) || (state == S_ISSUE);
    step.head  = (state == S_HEAD);
    step.first = (state == S_ISSUE) && (k == i);
    step.last  = (state == S_ISSUE) && k_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      len   <= '0;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            n     <= nmat;
            len   <= LW'(2);
            i     <= '0;
            j     <= IW'(1);
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          k     <= i;
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (k_last) begin
            if (j_end) begin
              state <= (len == n) ? S_FINISH : S_DRAIN;
            end else begin
              i     <= i + 1'b1;
              j     <= j + 1'b1;
              state <= S_HEAD;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            len   <= len + 1'b1;
            i     <= '0;
            j     <= IW'(len);
            state <= S_HEAD;
          end
        end
        S_FINISH: begin
          if (!pipe_busy) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_split_in_range: assert property (@(posedge clk) disable iff (rst)
    (step.valid && !step.head) |-> ((i <= k) && (k < j)))
    else $error("split point outside its interval");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    done |-> !pipe_busy)
    else $error("chain finished with steps still in flight");

endmodule

`default_nettype wire

/* design/matrix_chain_order_cost_top.sv */
// Top level of the matrix chain order cost block: chain loading, control and result output.
//
// A chain arrives one dimension per request; the request with last set closes it. A chain
// of one or two dimensions answers with cost 0 on the cycle after its closing request.
// Longer chains of n matrices then run through a shared four-stage multiply, add and minimum
// pipeline that takes one split point per cycle, except while the sequencer fetches each
// interval's bounding dimensions and while it drains the pipeline at each change of chain
// length. busy stays high while the chain is costed. The result appears on result for
// exactly one cycle with result_valid high and cannot be stalled; the next request may be
// taken in that same cycle.
`timescale 1ns / 1ps
`default_nettype none

module matrix_chain_order_cost_top import mcoc_pkg::*; #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 12
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output result_t       result,
  output logic          result_valid
);

  localparam int DEPTH = MAX_MATRICES + 1;
  localparam int CW    = $clog2(MAX_MATRICES + 2);
  localparam int DW    = $clog2(MAX_MATRICES + 1);
  localparam int LW    = $clog2(MAX_MATRICES + 1);
  localparam int IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;

  typedef enum logic {
    T_LOAD,
    T_RUN
  } state_t;

  state_t            state;
  logic [CW-1:0]     dim_count;
  logic              overflow_seen;
  logic              go;
  logic [LW-1:0]     nmat;

  logic              accept;
  logic              has_room;
  logic [CW-1:0]     count_next;
  logic              overflow_next;
  logic              wr_en;
  logic [DW-1:0]     wr_addr;
  logic [DIM_BITS-1:0] wr_data;

  step_t             step;
  logic [IW-1:0]     idx_i;
  logic [IW-1:0]     idx_j;
  logic [IW-1:0]     idx_k;
  logic              pipe_busy;
  logic              seq_done;
  logic [COST_W-1:0] cost;

  assign accept        = start && !busy;
  assign has_room      = (dim_count < CW'(DEPTH));
  assign count_next    = has_room ? (dim_count + 1'b1) : dim_count;
  assign overflow_next = overflow_seen || !has_room;
  assign wr_en         = accept && has_room;
  assign wr_addr       = dim_count[DW-1:0];
  assign wr_data       = DIM_BITS'(request.dimension);

  mcoc_seq #(
    .MAX_MATRICES(MAX_MATRICES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .nmat     (nmat),
    .pipe_busy(pipe_busy),
    .step     (step),
    .i        (idx_i),
    .j        (idx_j),
    .k        (idx_k),
    .done     (seq_done)
  );

  mcoc_unit #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_BITS    (DIM_BITS)
  ) u_unit (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .step     (step),
    .i        (idx_i),
    .j        (idx_j),
    .k        (idx_k),
    .pipe_busy(pipe_busy),
    .cost     (cost)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_LOAD;
      busy          <= 1'b0;
      dim_count     <= '0;
      overflow_seen <= 1'b0;
      go            <= 1'b0;
      nmat          <= '0;
      result        <= '0;
      result_valid  <= 1'b0;
    end else begin
      go           <= 1'b0;
      result_valid <= 1'b0;
      unique case (state)
        T_LOAD: begin
          if (accept) begin
            if (request.last) begin
              if (count_next >= CW'(3)) begin
                go            <= 1'b1;
                nmat          <= LW'(count_next - 1'b1);
                overflow_seen <= overflow_next;
                busy          <= 1'b1;
                state         <= T_RUN;
              end else begin
                result_valid    <= 1'b1;
                result.min_cost <= '0;
                result.overflow <= overflow_next;
                dim_count       <= '0;
                overflow_seen   <= 1'b0;
              end
            end else begin
              dim_count     <= count_next;
              overflow_seen <= overflow_next;
            end
          end
        end
        T_RUN: begin
          if (seq_done) begin
            result_valid    <= 1'b1;
            result.min_cost <= cost;
            result.overflow <= overflow_seen || (cost == COST_MAX);
            busy            <= 1'b0;
            dim_count       <= '0;
            overflow_seen   <= 1'b0;
            state           <= T_LOAD;
          end
        end
        default: state <= T_LOAD;
      endcase
    end
  end

  a_result_only_when_free: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while a chain is still being costed");

  a_run_after_closing: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && request.last))
    else $error("costing started without a closing request");

endmodule

`default_nettype wire
